// ----- hdl/pobd_pkg.sv -----
// Shared types, register codes and arithmetic helpers for the point to box distance core.
package pobd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int SQ_W       = 38;
	localparam int ROOT_W     = 19;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_U  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_V  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_W  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENTS = 3'd4;

	localparam logic [CFG_DATA_W-1:0] RST_CENTER  = 48'h0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_AXIS_U  = 48'h0000_0000_4000;
	localparam logic [CFG_DATA_W-1:0] RST_AXIS_V  = 48'h0000_4000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_AXIS_W  = 48'h4000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_EXTENTS = 48'h0100_0100_0100;

	typedef logic signed [15:0] coord_t;
	typedef logic signed [16:0] diff_t;

	// word handed from front to back
	typedef struct packed {
		diff_t  dx;
		diff_t  dy;
		diff_t  dz;
		coord_t cx;
		coord_t cy;
		coord_t cz;
	} work_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] axis_u;
		logic [CFG_DATA_W-1:0] axis_v;
		logic [CFG_DATA_W-1:0] axis_w;
		logic [CFG_DATA_W-1:0] extents;
	} box_cfg_t;

	typedef struct packed {
		logic [SQ_W-1:0] sq;
		coord_t          x;
		coord_t          y;
		coord_t          z;
	} result_t;

	function automatic coord_t field16(logic [CFG_DATA_W-1:0] r, int k);
		return coord_t'(r[16*k +: 16]);
	endfunction

	function automatic coord_t sat16(logic signed [21:0] v);
		if (v > 22'sd32767)
			return 16'sh7FFF;
		else if (v < -22'sd32768)
			return 16'sh8000;
		else
			return coord_t'(v);
	endfunction

	// coordinate plus time*vel rounded from Q12.20 to Q8.8, saturated
	function automatic coord_t move16(coord_t p, logic signed [32:0] prod);
		logic signed [33:0] r;
		logic signed [21:0] s;
		r = 34'(prod) + 34'sd2048;
		s = 22'(p) + 22'(r >>> 12);
		return sat16(s);
	endfunction

endpackage

// ----- hdl/pobd_ifs.sv -----
// Channel interfaces: query, result and configuration write.
interface pobd_query_if;
	import pobd_pkg::*;
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	coord_t point_vel_x;
	coord_t point_vel_y;
	coord_t point_vel_z;
	coord_t box_vel_x;
	coord_t box_vel_y;
	coord_t box_vel_z;
	logic [15:0] elapsed_time;
	modport source (output valid, point_x, point_y, point_z, point_vel_x, point_vel_y,
		point_vel_z, box_vel_x, box_vel_y, box_vel_z, elapsed_time, input ready);
	modport sink (input valid, point_x, point_y, point_z, point_vel_x, point_vel_y,
		point_vel_z, box_vel_x, box_vel_y, box_vel_z, elapsed_time, output ready);
endinterface

interface pobd_result_if;
	import pobd_pkg::*;
	logic              valid;
	logic              ready;
	logic [SQ_W-1:0]   squared_distance;
	logic [ROOT_W-1:0] distance;
	coord_t            closest_x;
	coord_t            closest_y;
	coord_t            closest_z;
	modport source (output valid, squared_distance, distance, closest_x, closest_y,
		closest_z, input ready);
	modport sink (input valid, squared_distance, distance, closest_x, closest_y,
		closest_z, output ready);
endinterface

interface pobd_cfg_if;
	import pobd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/pobd_front.sv -----
// Front end: accepts queries, advances point and centre, forms the offset word.
module pobd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	pobd_query_if.sink                     query,
	input  logic [pobd_pkg::CFG_DATA_W-1:0] center,
	output logic                           push,
	output pobd_pkg::work_t                push_word,
	input  logic                           push_ready
);
	import pobd_pkg::*;

	logic               en;
	logic               v_s1, v_s2;
	coord_t             pt_s1 [3];
	logic signed [32:0] pv_s1 [3];
	logic signed [32:0] bv_s1 [3];
	logic signed [16:0] t_ext;
	coord_t             pt_in [3];
	coord_t             pvel [3];
	coord_t             bvel [3];
	coord_t             mp [3];
	coord_t             mc [3];
	work_t              work_s2;

	assign en          = !(v_s2 && !push_ready);
	assign query.ready = en;
	assign push        = v_s2 && push_ready;
	assign push_word   = work_s2;
	assign t_ext       = signed'({1'b0, query.elapsed_time});

	always_comb begin
		pt_in[0] = query.point_x;     pt_in[1] = query.point_y;     pt_in[2] = query.point_z;
		pvel[0]  = query.point_vel_x; pvel[1]  = query.point_vel_y; pvel[2]  = query.point_vel_z;
		bvel[0]  = query.box_vel_x;   bvel[1]  = query.box_vel_y;   bvel[2]  = query.box_vel_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pt_s1[j] <= pt_in[j];
				pv_s1[j] <= t_ext * pvel[j];
				bv_s1[j] <= t_ext * bvel[j];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mp[j] = move16(pt_s1[j], pv_s1[j]);
			mc[j] = move16(field16(center, j), bv_s1[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s2.dx <= 17'(mp[0]) - 17'(mc[0]);
			work_s2.dy <= 17'(mp[1]) - 17'(mc[1]);
			work_s2.dz <= 17'(mp[2]) - 17'(mc[2]);
			work_s2.cx <= mc[0];
			work_s2.cy <= mc[1];
			work_s2.cz <= mc[2];
		end
	end

endmodule

// ----- hdl/pobd_fifo.sv -----
// Short queue of offset words between front and back.
module pobd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pobd_pkg::work_t push_word,
	output logic            push_ready,
	input  logic            pop,
	output pobd_pkg::work_t pop_word,
	output logic            pop_valid
);
	import pobd_pkg::*;

	work_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_pop;

	assign push_ready = (count_q != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_word   = mem[rd_ptr_q];
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- hdl/pobd_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with side payload.
module pobd_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  pobd_pkg::result_t            in_res,
	output logic                         out_valid,
	output pobd_pkg::result_t            out_res,
	output logic [pobd_pkg::ROOT_W-1:0]  out_root
);
	import pobd_pkg::*;

	logic              vld  [ROOT_W+1];
	result_t           res  [ROOT_W+1];
	logic [SQ_W-1:0]   rem  [ROOT_W+1];
	logic [ROOT_W-1:0] root [ROOT_W+1];

	assign vld[0]  = in_valid;
	assign res[0]  = in_res;
	assign rem[0]  = in_res.sq;
	assign root[0] = '0;

	for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
		localparam int K = ROOT_W - 1 - s;
		logic [SQ_W+1:0] trial;
		logic            take;

		// (root + 2^K)^2 - root^2 = root*2^(K+1) + 2^(2K)
		assign trial = ((SQ_W+2)'(root[s]) << (K + 1)) + ((SQ_W+2)'(1) << (2 * K));
		assign take  = ((SQ_W+2)'(rem[s]) >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld[s+1] <= 1'b0;
			else if (en)
				vld[s+1] <= vld[s];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				res[s+1]  <= res[s];
				rem[s+1]  <= take ? SQ_W'((SQ_W+2)'(rem[s]) - trial) : rem[s];
				root[s+1] <= take ? (root[s] | (ROOT_W'(1) << K)) : root[s];
			end
		end
	end

	assign out_valid = vld[ROOT_W];
	assign out_res   = res[ROOT_W];
	assign out_root  = root[ROOT_W];

endmodule

// ----- hdl/pobd_back.sv -----
// Back end: projection, clamp, squared distance, closest point, root, output register.
module pobd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pobd_pkg::box_cfg_t box,
	input  logic               pop_valid,
	input  pobd_pkg::work_t    pop_word,
	output logic               pop,
	pobd_result_if.source      result
);
	import pobd_pkg::*;

	logic               en;
	logic               v_b1, v_b2, v_b3, v_b4, v_out_q;
	coord_t             axis [3][3];
	logic [15:0]        ext [3];
	diff_t              dw [3];
	coord_t             mc_b1 [3], mc_b2 [3], mc_b3 [3];
	logic signed [32:0] pd_b1 [3][3];
	logic signed [20:0] proj [3];
	logic signed [21:0] d_b2 [3];
	logic signed [16:0] cl_b2 [3];
	logic [43:0]        dsq_b3 [3];
	logic signed [32:0] pc_b3 [3][3];
	result_t            res_b4;
	logic               sq_v;
	result_t            sq_res;
	logic [ROOT_W-1:0]  sq_root;
	result_t            res_out_q;
	logic [ROOT_W-1:0]  root_out_q;

	assign en  = !v_out_q || result.ready;
	assign pop = en && pop_valid;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			axis[0][j] = field16(box.axis_u, j);
			axis[1][j] = field16(box.axis_v, j);
			axis[2][j] = field16(box.axis_w, j);
			ext[j]     = box.extents[16*j +: 16];
		end
		dw[0] = pop_word.dx;
		dw[1] = pop_word.dy;
		dw[2] = pop_word.dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1    <= 1'b0;
			v_b2    <= 1'b0;
			v_b3    <= 1'b0;
			v_b4    <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			v_b1    <= pop_valid;
			v_b2    <= v_b1;
			v_b3    <= v_b2;
			v_b4    <= v_b3;
			v_out_q <= sq_v;
		end
	end

	// b1: offset times each axis component
	always_ff @(posedge clk) begin
		if (en) begin
			mc_b1[0] <= pop_word.cx;
			mc_b1[1] <= pop_word.cy;
			mc_b1[2] <= pop_word.cz;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					pd_b1[i][j] <= dw[j] * axis[i][j];
		end
	end

	// b2: projection rounded to Q8.8, clamped to the extent
	always_comb begin
		for (int i = 0; i < 3; i++)
			proj[i] = 21'((35'(pd_b1[i][0]) + 35'(pd_b1[i][1]) + 35'(pd_b1[i][2])
				+ 35'sd8192) >>> 14);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mc_b2[i] <= mc_b1[i];
				if (proj[i] < -signed'(21'(ext[i]))) begin
					d_b2[i]  <= 22'(proj[i]) + signed'(22'(ext[i]));
					cl_b2[i] <= -signed'(17'(ext[i]));
				end else if (proj[i] > signed'(21'(ext[i]))) begin
					d_b2[i]  <= 22'(proj[i]) - signed'(22'(ext[i]));
					cl_b2[i] <= signed'(17'(ext[i]));
				end else begin
					d_b2[i]  <= '0;
					cl_b2[i] <= 17'(proj[i]);
				end
			end
		end
	end

	// b3: squared overshoots and clamped terms mapped back through the axes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mc_b3[i]  <= mc_b2[i];
				dsq_b3[i] <= 44'(d_b2[i] * d_b2[i]);
				for (int j = 0; j < 3; j++)
					pc_b3[i][j] <= cl_b2[i] * axis[i][j];
			end
		end
	end

	// b4: sums, saturation
	always_ff @(posedge clk) begin
		logic [45:0]        sum;
		logic signed [34:0] acc [3];
		coord_t             cp [3];
		if (en) begin
			sum = 46'(dsq_b3[0]) + 46'(dsq_b3[1]) + 46'(dsq_b3[2]);
			res_b4.sq <= (|sum[45:SQ_W]) ? {SQ_W{1'b1}} : sum[SQ_W-1:0];
			for (int j = 0; j < 3; j++) begin
				acc[j] = 35'(pc_b3[0][j]) + 35'(pc_b3[1][j]) + 35'(pc_b3[2][j]) + 35'sd8192;
				cp[j]  = sat16(22'(mc_b3[j]) + 22'(acc[j] >>> 14));
			end
			res_b4.x <= cp[0];
			res_b4.y <= cp[1];
			res_b4.z <= cp[2];
		end
	end

	pobd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_b4),
		.in_res   (res_b4),
		.out_valid(sq_v),
		.out_res  (sq_res),
		.out_root (sq_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			res_out_q  <= sq_res;
			root_out_q <= sq_root;
		end
	end

	assign result.valid            = v_out_q;
	assign result.squared_distance = res_out_q.sq;
	assign result.distance         = root_out_q;
	assign result.closest_x        = res_out_q.x;
	assign result.closest_y        = res_out_q.y;
	assign result.closest_z        = res_out_q.z;

endmodule

// ----- hdl/point_to_oriented_box_distance_core.sv -----
// Top level: box registers, front end, queue and back end.
//
//  channel  dir  handshake      word
//  query    in   valid/ready    point, point and box velocity, elapsed time
//  result   out  valid/ready    squared distance, distance, closest point
//  cfg      in   valid/ready    register index, 48-bit data (ready always high)
//
// One query per cycle sustained while results are taken; a query passes the front end, the
// queue and the back end (4 arithmetic stages, 19 square-root stages, output).
// The square-root pipeline, one result bit per stage, sets the depth.
// Reset loads the default box: centre at origin, unit axes, half-extents of 1.0.
// A stalled result freezes the back end; the 4-word queue lets the front keep going.
module point_to_oriented_box_distance_core (
	input  logic          clk,
	input  logic          arst_n,
	pobd_query_if.sink    query,
	pobd_result_if.source result,
	pobd_cfg_if.sink      cfg
);
	import pobd_pkg::*;

	logic [CFG_DATA_W-1:0] center_q;
	box_cfg_t              box_q;
	logic                  push, push_ready, pop, pop_valid;
	work_t                 push_word, pop_word;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q      <= RST_CENTER;
			box_q.axis_u  <= RST_AXIS_U;
			box_q.axis_v  <= RST_AXIS_V;
			box_q.axis_w  <= RST_AXIS_W;
			box_q.extents <= RST_EXTENTS;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTER:  center_q      <= cfg.data;
				REG_AXIS_U:  box_q.axis_u  <= cfg.data;
				REG_AXIS_V:  box_q.axis_v  <= cfg.data;
				REG_AXIS_W:  box_q.axis_w  <= cfg.data;
				REG_EXTENTS: box_q.extents <= cfg.data;
				default: ;
			endcase
		end
	end

	pobd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.center    (center_q),
		.push      (push),
		.push_word (push_word),
		.push_ready(push_ready)
	);

	pobd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.push_ready(push_ready),
		.pop       (pop),
		.pop_word  (pop_word),
		.pop_valid (pop_valid)
	);

	pobd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.box      (box_q),
		.pop_valid(pop_valid),
		.pop_word (pop_word),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ----- bench/tb_pobd_ifs.sv -----
// Bench copy note: channel interfaces come from the RTL; this file holds the query and answer word types.
package tb_pobd_types;
	import pobd_pkg::*;

	typedef struct {
		coord_t p [3];
		coord_t pv [3];
		coord_t bv [3];
		logic [15:0] t;
	} query_word_t;

	typedef struct {
		logic [SQ_W-1:0]   sq;
		logic [ROOT_W-1:0] dist_val;
		coord_t            c [3];
	} answer_t;
endpackage

// ----- bench/tb_point_to_oriented_box_distance_core.sv -----
// Testbench: random and directed queries against a behavioral box-distance predictor.
module tb_point_to_oriented_box_distance_core;
	timeunit 1ns;
	timeprecision 1ps;
	import pobd_pkg::*;
	import tb_pobd_types::*;

	// index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	pobd_query_if  query ();
	pobd_result_if result ();
	pobd_cfg_if    cfg ();

	point_to_oriented_box_distance_core uut (
		.clk(clk), .arst_n(arst_n), .query(query), .result(result), .cfg(cfg));

	// predictor copy of the box registers
	logic [CFG_DATA_W-1:0] box_regs [5];
	query_word_t pending [$];
	answer_t     expected [$];
	int errors = 0;
	bit feed_hold = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	bit in_taken = 1'b0;
	bit out_taken = 1'b0;

	function automatic longint fld(logic [CFG_DATA_W-1:0] r, int k);
		return longint'(coord_t'(r[16*k +: 16]));
	endfunction

	// floor(v/2^s) after adding half
	function automatic longint rnd_shr(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic answer_t predict_box_distance(query_word_t q);
		answer_t a;
		longint mp, mc [3], dif [3], clampd [3], ax [3][3], ext, acc, pr, d;
		longint unsigned sq, rem, root, bit_v;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				ax[i][j] = fld(box_regs[REG_AXIS_U + i], j);
		for (int j = 0; j < 3; j++) begin
			mp = clip16(longint'(q.p[j]) + rnd_shr(longint'(q.t) * longint'(q.pv[j]), 12));
			mc[j] = clip16(fld(box_regs[REG_CENTER], j)
				+ rnd_shr(longint'(q.t) * longint'(q.bv[j]), 12));
			dif[j] = mp - mc[j];
		end
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			ext = longint'(box_regs[REG_EXTENTS][16*i +: 16]);
			acc = 0;
			for (int j = 0; j < 3; j++) acc += dif[j] * ax[i][j];
			pr = rnd_shr(acc, 14);
			if (pr < -ext) begin
				d = pr + ext; sq += longint'(d * d); pr = -ext;
			end else if (pr > ext) begin
				d = pr - ext; sq += longint'(d * d); pr = ext;
			end
			clampd[i] = pr;
		end
		if (sq > (64'd1 << 38) - 1) sq = (64'd1 << 38) - 1;
		a.sq = sq[SQ_W-1:0];
		rem = sq; root = 0; bit_v = 64'd1 << 62;
		while (bit_v > rem) bit_v >>= 2;
		while (bit_v != 0) begin
			if (rem >= root + bit_v) begin
				rem -= root + bit_v; root = (root >> 1) + bit_v;
			end else
				root >>= 1;
			bit_v >>= 2;
		end
		a.dist_val = root[ROOT_W-1:0];
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int i = 0; i < 3; i++) acc += clampd[i] * ax[i][j];
			a.c[j] = coord_t'(clip16(mc[j] + rnd_shr(acc, 14)));
		end
		return a;
	endfunction

	// handshakes as seen at the rising edge
	always @(posedge clk) begin
		in_taken <= query.valid && query.ready;
		out_taken <= result.valid && result.ready;
	end

	// driver: presents queued words with random gaps
	always @(negedge clk) begin
		if (in_taken) begin
			expected.push_back(predict_box_distance(pending.pop_front()));
			gap_left = $urandom_range(0, 10);
		end
		if (!arst_n) begin
			query.valid <= 1'b0;
		end else if (query.valid && !in_taken) begin
			query.valid <= 1'b1;
		end else if (feed_hold || pending.size() == 0) begin
			query.valid <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left--;
			query.valid <= 1'b0;
		end else begin
			query.valid <= 1'b1;
			query.point_x <= pending[0].p[0];
			query.point_y <= pending[0].p[1];
			query.point_z <= pending[0].p[2];
			query.point_vel_x <= pending[0].pv[0];
			query.point_vel_y <= pending[0].pv[1];
			query.point_vel_z <= pending[0].pv[2];
			query.box_vel_x <= pending[0].bv[0];
			query.box_vel_y <= pending[0].bv[1];
			query.box_vel_z <= pending[0].bv[2];
			query.elapsed_time <= pending[0].t;
		end
	end

	// result side: random stalls; check on the rising edge
	always @(negedge clk) begin
		if (out_taken) begin
			stall_left = $urandom_range(0, 10);
			if (stall_left > 0 && ($urandom_range(0, 3) == 0)) stall_left = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (result.valid && result.ready) begin
			if (expected.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				e = expected.pop_front();
				if (result.squared_distance !== e.sq) begin
					$error("squared_distance exp %0d got %0d", e.sq, result.squared_distance);
					errors++;
				end
				if (result.distance !== e.dist_val) begin
					$error("distance exp %0d got %0d", e.dist_val, result.distance);
					errors++;
				end
				if (result.closest_x !== e.c[0]) begin
					$error("closest_x exp %0d got %0d", e.c[0], result.closest_x);
					errors++;
				end
				if (result.closest_y !== e.c[1]) begin
					$error("closest_y exp %0d got %0d", e.c[1], result.closest_y);
					errors++;
				end
				if (result.closest_z !== e.c[2]) begin
					$error("closest_z exp %0d got %0d", e.c[2], result.closest_z);
					errors++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending.size() != 0 || query.valid || expected.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx <= REG_EXTENTS) box_regs[idx] = val;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom());
			1: return coord_t'($urandom_range(0, 2047) - 1024);
			default: return coord_t'($urandom_range(0, 255) - 128);
		endcase
	endfunction

	task automatic add_query(int mode);
		query_word_t q;
		for (int j = 0; j < 3; j++) begin
			q.p[j] = rand_coord(mode);
			q.pv[j] = rand_coord(mode);
			q.bv[j] = rand_coord(mode);
		end
		case ($urandom_range(0, 3))
			0: q.t = 16'd0;
			1: q.t = 16'(1 << $urandom_range(0, 15));
			default: q.t = 16'($urandom());
		endcase
		pending.push_back(q);
	endtask

	task automatic add_fixed(coord_t pv, coord_t v, logic [15:0] t);
		query_word_t q;
		for (int j = 0; j < 3; j++) begin
			q.p[j] = pv; q.pv[j] = v; q.bv[j] = -v;
		end
		q.t = t;
		pending.push_back(q);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_axis();
		logic [CFG_DATA_W-1:0] r;
		r = {16'($urandom()), 32'($urandom())};
		if ($urandom_range(0, 1)) begin
			r = 48'h0;
			r[16*$urandom_range(0, 2) +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
		end
		return r;
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] ctr;
		query.valid = 1'b0;
		query.point_x = '0; query.point_y = '0; query.point_z = '0;
		query.point_vel_x = '0; query.point_vel_y = '0; query.point_vel_z = '0;
		query.box_vel_x = '0; query.box_vel_y = '0; query.box_vel_z = '0;
		query.elapsed_time = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		box_regs[REG_CENTER] = RST_CENTER;
		box_regs[REG_AXIS_U] = RST_AXIS_U;
		box_regs[REG_AXIS_V] = RST_AXIS_V;
		box_regs[REG_AXIS_W] = RST_AXIS_W;
		box_regs[REG_EXTENTS] = RST_EXTENTS;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: static, extremes, saturation of motion, inside box
		add_fixed(16'sh0000, 16'sh0000, 16'h0000);
		add_fixed(16'sh0080, 16'sh0000, 16'h0000);
		add_fixed(16'sh7FFF, 16'sh0000, 16'h0000);
		add_fixed(-16'sh8000, 16'sh0000, 16'h0000);
		add_fixed(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
		add_fixed(-16'sh8000, -16'sh8000, 16'hFFFF);
		add_fixed(16'sh0100, 16'sh0100, 16'h1000);
		add_fixed(16'sh0000, -16'sh8000, 16'h0001);
		add_fixed(16'sh5555, 16'shAAAA, 16'hAAAA);
		add_fixed(-16'sh5556, 16'sh5555, 16'h5555);
		wait_drained();

		// overflow of the squared distance: huge skewed axes, zero extents
		write_reg(REG_AXIS_U, 48'h7FFF_7FFF_7FFF);
		write_reg(REG_AXIS_V, 48'h8000_8000_8000);
		write_reg(REG_AXIS_W, 48'h7FFF_8000_7FFF);
		write_reg(REG_EXTENTS, 48'h0);
		write_reg(REG_CENTER, 48'h8000_8000_8000);
		write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
		add_fixed(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
		add_fixed(-16'sh8000, 16'sh0000, 16'h0000);
		add_fixed(16'sh7FFF, 16'sh0000, 16'h0000);
		add_fixed(16'sh1234, -16'sh1234, 16'h8000);
		wait_drained();
		write_reg(REG_EXTENTS, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_CENTER, 48'h7FFF_7FFF_7FFF);
		add_fixed(-16'sh8000, 16'sh7FFF, 16'hFFFF);
		add_fixed(16'sh0000, 16'sh0000, 16'h0000);

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			ctr = {16'($urandom()), 32'($urandom())};
			write_reg(REG_CENTER, ph == 0 ? 48'h0 : ctr);
			write_reg(REG_AXIS_U, rand_axis());
			write_reg(REG_AXIS_V, rand_axis());
			write_reg(REG_AXIS_W, rand_axis());
			write_reg(REG_EXTENTS, ph == 1 ? 48'hFFFF_FFFF_FFFF :
				{16'($urandom_range(0, 2048)), 16'($urandom()), 16'($urandom_range(0, 1024))});
			for (int k = 0; k < 235; k++) add_query($urandom_range(0, 2));
			if (ph == 3) begin
				// let the pipe drain with the sender held
				while (pending.size() > 100) @(posedge clk);
				feed_hold = 1'b1;
				while (query.valid || expected.size() != 0) @(posedge clk);
				feed_hold = 1'b0;
			end
		end
		wait_drained();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
